FILE: hw/rtl/iair_pkg.sv
// Shared types, codes and constants for the indexed array insert/remove block.
`default_nettype none

package iair_pkg;

    localparam int WORD_W       = 32;
    localparam int IDX_W        = 6;
    localparam int STAT_W       = 2;
    localparam int LEN_W        = 7;
    // wide enough for any count up to the largest supported capacity
    localparam int CNT_W        = 11;
    localparam int CAPACITY_DEF = 64;
    // only the first 2**IDX_W entries can ever be addressed for read-back
    localparam int READ_SPAN    = 64;
    localparam int READ_GRP     = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_REMOVE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;

    typedef enum logic [2:0] {
        C_HOLD,
        C_GROW,
        C_SHIFT_UP,
        C_SET,
        C_SHIFT_DOWN
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_APPLY,
        S_RB1,
        S_RB2,
        S_OUT
    } ctl_state_t;

    typedef struct packed {
        cell_op_t          op;
        logic [CNT_W-1:0]  idx;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] val;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iair_in_if.sv
// Request channel: command, index and value with valid/ready.
`default_nettype none

interface iair_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic        [iair_pkg::IDX_W-1:0]     index;
    logic signed [iair_pkg::WORD_W-1:0]    value;

    modport source (output valid, command, index, value, input ready);
    modport sink   (input valid, command, index, value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/iair_out_if.sv
// Response channel: status, length and element with valid/ready.
`default_nettype none

interface iair_out_if;
    logic                                  valid;
    logic                                  ready;
    logic        [iair_pkg::STAT_W-1:0]    status;
    logic        [iair_pkg::LEN_W-1:0]     length;
    logic signed [iair_pkg::WORD_W-1:0]    element_at_index;

    modport source (output valid, status, length, element_at_index, input ready);
    modport sink   (input valid, status, length, element_at_index, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/iair_cell.sv
// One storage cell of the array: holds one word, shifts with its neighbours.
`default_nettype none

module iair_cell #(
    parameter int POS = 0
) (
    input  wire                                 clk,
    input  iair_pkg::cell_ctrl_t                ctrl,
    input  wire  [iair_pkg::WORD_W-1:0]         prev_data,
    input  wire  [iair_pkg::WORD_W-1:0]         next_data,
    output logic [iair_pkg::WORD_W-1:0]         data
);

    localparam logic [iair_pkg::CNT_W-1:0] P = iair_pkg::CNT_W'(POS);

    logic [iair_pkg::WORD_W-1:0] data_reg;
    logic [iair_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            iair_pkg::C_HOLD:
            begin
                data_next = data_reg;
            end
            iair_pkg::C_GROW:
            begin
                // zero-fill the gap between old length and index
                if (P == ctrl.idx)
                    data_next = ctrl.val;
                else if (P >= ctrl.count && P < ctrl.idx)
                    data_next = '0;
            end
            iair_pkg::C_SHIFT_UP:
            begin
                if (P == ctrl.idx)
                    data_next = ctrl.val;
                else if (P > ctrl.idx)
                    data_next = prev_data;
            end
            iair_pkg::C_SET:
            begin
                if (P == ctrl.idx)
                    data_next = ctrl.val;
            end
            iair_pkg::C_SHIFT_DOWN:
            begin
                if (P >= ctrl.idx)
                    data_next = next_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/iair_rdtree.sv
// Two-stage registered select tree: reads the cell at a given index.
`default_nettype none

module iair_rdtree #(
    parameter int N = iair_pkg::READ_SPAN
) (
    input  wire                                 clk,
    input  wire  [iair_pkg::IDX_W-1:0]          idx,
    input  wire  [iair_pkg::WORD_W-1:0]         taps [N],
    output logic [iair_pkg::WORD_W-1:0]         rd
);

    localparam int GRP = iair_pkg::READ_GRP;
    localparam int NG  = (N + GRP - 1) / GRP;

    logic [iair_pkg::WORD_W-1:0] gated  [NG*GRP];
    logic [iair_pkg::WORD_W-1:0] grp_reg [NG];
    logic [iair_pkg::WORD_W-1:0] grp_next [NG];
    logic [iair_pkg::WORD_W-1:0] rd_reg;
    logic [iair_pkg::WORD_W-1:0] rd_next;

    genvar j;
    generate
        for (j = 0; j < NG*GRP; j++)
        begin : g_gate
            if (j < N)
            begin : g_real
                assign gated[j] = (idx == iair_pkg::IDX_W'(j)) ? taps[j] : '0;
            end
            else
            begin : g_pad
                assign gated[j] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP; k++)
                grp_next[g] = grp_next[g] | gated[g*GRP + k];
        end
        rd_next = '0;
        for (int g = 0; g < NG; g++)
            rd_next = rd_next | grp_reg[g];
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
        rd_reg  <= rd_next;
    end

    assign rd = rd_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_array_insert_remove.sv
// Top level: ordered word array with indexed insert and remove.
`default_nettype none

// Keeps an ordered array of up to CAPACITY signed 32-bit words plus its length.
// Each request item is an insert (value at index) or a remove (entry at index);
// each produces one response item with status, new length and the word now at
// the index (zero when the index lies at or beyond the length). An insert past
// the end zero-fills up to the index; an insert onto a nonzero entry shifts
// the tail up; an insert onto a zero entry overwrites it. The words live in a
// row of cells that all shift by one place in the same cycle. Reads of the
// entry at the index go through a two-stage registered select tree, which is
// used twice per item (old entry before the edit, new entry after it), so the
// response item is offered only after the states RD1, RD2, APPLY, RB1, RB2 and
// OUT, one item at a time. The request side is ready only when the block is
// idle, so a new item is taken only after the last response is loaded. A
// waiting response sits in an output register and holds off only the final step
// of the following item. There is no clearing pass: array contents are undefined
// after reset, which is harmless since only entries below the length are read.

module indexed_array_insert_remove #(
    parameter int CAPACITY = iair_pkg::CAPACITY_DEF
) (
    input wire        clk,
    input wire        rst_n,
    iair_in_if.sink   req,
    iair_out_if.source rsp
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int READ_N = (CAPACITY < iair_pkg::READ_SPAN) ? CAPACITY
                                                              : iair_pkg::READ_SPAN;
    localparam logic [iair_pkg::CNT_W-1:0] CAP_X = iair_pkg::CNT_W'(CAPACITY);

    // control
    iair_pkg::ctl_state_t state_reg;
    iair_pkg::ctl_state_t state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    // captured item
    logic                          cmd_reg;
    logic [iair_pkg::IDX_W-1:0]    idx_reg;
    logic [iair_pkg::WORD_W-1:0]   val_reg;
    logic [iair_pkg::STAT_W-1:0]   stat_reg;
    logic [iair_pkg::STAT_W-1:0]   stat_next;

    // response register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [iair_pkg::STAT_W-1:0]   out_stat_reg;
    logic [iair_pkg::LEN_W-1:0]    out_len_reg;
    logic [iair_pkg::WORD_W-1:0]   out_elem_reg;

    logic                          accept;
    logic                          out_free;
    logic                          load_out;
    logic [iair_pkg::CNT_W-1:0]    idx_x;
    logic [iair_pkg::CNT_W-1:0]    count_x;
    logic [iair_pkg::WORD_W-1:0]   rd;
    logic [iair_pkg::WORD_W-1:0]   elem;
    iair_pkg::cell_op_t            op;
    iair_pkg::cell_ctrl_t          ctrl;

    logic [iair_pkg::WORD_W-1:0]   cell_data [CAPACITY];
    logic [iair_pkg::WORD_W-1:0]   taps      [READ_N];

    assign idx_x    = iair_pkg::CNT_W'(idx_reg);
    assign count_x  = iair_pkg::CNT_W'(count_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;

    // ---- cell row ----
    assign ctrl.op    = op;
    assign ctrl.idx   = idx_x;
    assign ctrl.count = count_x;
    assign ctrl.val   = val_reg;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [iair_pkg::WORD_W-1:0] prev_d;
            logic [iair_pkg::WORD_W-1:0] next_d;
            if (i == 0)
            begin : g_first
                assign prev_d = '0;
            end
            else
            begin : g_mid_p
                assign prev_d = cell_data[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign next_d = cell_data[i];
            end
            else
            begin : g_mid_n
                assign next_d = cell_data[i+1];
            end
            iair_cell #(
                .POS(i)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[i])
            );
        end
        for (i = 0; i < READ_N; i++)
        begin : g_tap
            assign taps[i] = cell_data[i];
        end
    endgenerate

    iair_rdtree #(
        .N(READ_N)
    ) u_rdtree (
        .clk  (clk),
        .idx  (idx_reg),
        .taps (taps),
        .rd   (rd)
    );

    // ---- sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iair_pkg::S_IDLE:  if (req.valid) state_next = iair_pkg::S_RD1;
            iair_pkg::S_RD1:   state_next = iair_pkg::S_RD2;
            iair_pkg::S_RD2:   state_next = iair_pkg::S_APPLY;
            iair_pkg::S_APPLY: state_next = iair_pkg::S_RB1;
            iair_pkg::S_RB1:   state_next = iair_pkg::S_RB2;
            iair_pkg::S_RB2:   state_next = iair_pkg::S_OUT;
            iair_pkg::S_OUT:   if (out_free) state_next = iair_pkg::S_IDLE;
            default:           state_next = iair_pkg::S_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb
    begin
        req.ready  = (state_reg == iair_pkg::S_IDLE);
        op         = iair_pkg::C_HOLD;
        count_next = count_reg;
        stat_next  = stat_reg;
        load_out   = 1'b0;

        unique case (state_reg)
            iair_pkg::S_APPLY:
            begin
                // rd holds the entry at the index before the edit
                stat_next = iair_pkg::ST_DONE;
                if (cmd_reg == iair_pkg::CMD_REMOVE)
                begin
                    if (idx_x >= count_x)
                        stat_next = iair_pkg::ST_BAD_REMOVE;
                    else
                    begin
                        op         = iair_pkg::C_SHIFT_DOWN;
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (idx_x >= count_x)
                begin
                    // growing insert
                    if (idx_x >= CAP_X)
                        stat_next = iair_pkg::ST_FULL;
                    else
                    begin
                        op         = iair_pkg::C_GROW;
                        count_next = CW'(idx_x + iair_pkg::CNT_W'(1));
                    end
                end
                else if (rd != '0)
                begin
                    // shifting insert
                    if (count_x >= CAP_X)
                        stat_next = iair_pkg::ST_FULL;
                    else
                    begin
                        op         = iair_pkg::C_SHIFT_UP;
                        count_next = count_reg + CW'(1);
                    end
                end
                else
                begin
                    op = iair_pkg::C_SET;
                end
            end
            iair_pkg::S_OUT:
            begin
                load_out = out_free;
            end
            default:
            begin
                op = iair_pkg::C_HOLD;
            end
        endcase
    end

    // rd now holds the entry after the edit
    assign elem = (idx_x < count_x) ? rd : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iair_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            idx_reg <= req.index;
            val_reg <= req.value;
        end
        stat_reg <= stat_next;
        if (load_out)
        begin
            out_stat_reg <= stat_reg;
            out_len_reg  <= iair_pkg::LEN_W'(count_x);
            out_elem_reg <= elem;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_stat_reg;
    assign rsp.length           = out_len_reg;
    assign rsp.element_at_index = out_elem_reg;

    // ---- checks ----
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_x <= CAP_X)
        else $error("length above capacity");

    a_edit_only_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (op != iair_pkg::C_HOLD) |-> (state_reg == iair_pkg::S_APPLY))
        else $error("cell edit outside apply step");

    a_resp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == iair_pkg::S_OUT))
        else $error("response raised outside final step");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != iair_pkg::S_APPLY) |=> $stable(count_reg))
        else $error("length changed outside apply step");

endmodule

`default_nettype wire

FILE: tb/sv/tb_indexed_array_insert_remove.sv
// Testbench for the indexed array insert/remove block: shadow array, random edits, reply checks.
`timescale 1ns / 1ps

module tb_indexed_array_insert_remove;

    localparam int CAPACITY = iair_pkg::CAPACITY_DEF;
    localparam int WORD_W   = iair_pkg::WORD_W;
    localparam int IDX_W    = iair_pkg::IDX_W;
    localparam int STAT_W   = iair_pkg::STAT_W;
    localparam int LEN_W    = iair_pkg::LEN_W;

    // One reply item as the block should offer it.
    typedef struct {
        logic        [STAT_W-1:0] status;
        logic        [LEN_W-1:0]  length;
        logic signed [WORD_W-1:0] element;
    } edit_reply_t;

    // Shadow copy of the array plus the queue of replies still owed by the block.
    class array_scoreboard;
        logic signed [WORD_W-1:0] shadow_words [CAPACITY];
        int unsigned              shadow_len;
        edit_reply_t              due_replies [$];
        int unsigned              errors;

        function new();
            foreach (shadow_words[i]) shadow_words[i] = '0;
            shadow_len = 0;
            errors     = 0;
        endfunction

        // Apply one accepted request item to the shadow array and queue its reply.
        function void note_edit(logic cmd, logic [IDX_W-1:0] idx,
                                logic signed [WORD_W-1:0] val);
            edit_reply_t r;
            int unsigned ix;
            int unsigned i;
            ix       = 32'(idx);
            r.status = iair_pkg::ST_DONE;
            if (cmd == iair_pkg::CMD_INSERT)
            begin
                if (ix >= shadow_len)
                begin
                    // append past the end: zero-fill the gap
                    if (ix + 1 > CAPACITY)
                        r.status = iair_pkg::ST_FULL;
                    else
                    begin
                        for (i = shadow_len; i < ix; i++) shadow_words[i] = '0;
                        shadow_words[ix] = val;
                        shadow_len       = ix + 1;
                    end
                end
                else if (shadow_words[ix] != 0)
                begin
                    // occupied slot: tail moves up one place
                    if (shadow_len + 1 > CAPACITY)
                        r.status = iair_pkg::ST_FULL;
                    else
                    begin
                        for (i = shadow_len; i > ix; i--) shadow_words[i] = shadow_words[i-1];
                        shadow_words[ix] = val;
                        shadow_len++;
                    end
                end
                else
                    shadow_words[ix] = val;
            end
            else
            begin
                if (ix >= shadow_len)
                    r.status = iair_pkg::ST_BAD_REMOVE;
                else
                begin
                    for (i = ix; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            r.length  = LEN_W'(shadow_len);
            r.element = (ix < shadow_len) ? shadow_words[ix] : '0;
            due_replies.push_back(r);
        endfunction

        function void check_reply(logic [STAT_W-1:0] st, logic [LEN_W-1:0] len,
                                  logic signed [WORD_W-1:0] el);
            edit_reply_t e;
            if (due_replies.size() == 0)
            begin
                $error("reply with nothing outstanding: status %0d length %0d element %0d",
                       st, len, el);
                errors++;
                return;
            end
            e = due_replies.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (len !== e.length)
            begin
                $error("length: expected %0d, actual %0d", e.length, len);
                errors++;
            end
            if (el !== e.element)
            begin
                $error("element_at_index: expected %0d, actual %0d", e.element, el);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    iair_in_if  req_ch ();
    iair_out_if rsp_ch ();

    indexed_array_insert_remove #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    array_scoreboard sb;

    // Idle control: percentages per phase, calm switches all idling off near the end.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    bit          calm      = 1'b0;
    int unsigned stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request item and hold it until taken; maybe idle afterwards.
    task automatic send_edit(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic signed [WORD_W-1:0] val);
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.index   <= idx;
        req_ch.value   <= val;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_edit(cmd, idx, val);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Values: plenty of zeros (to hit the overwrite path), small words, extremes, noise.
    function automatic logic signed [WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return '0;
        if (r < 50) return WORD_W'($urandom_range(1, 15));
        if (r < 54) return 32'sh7FFF_FFFF;
        if (r < 58) return 32'sh8000_0000;
        if (r < 62) return -32'sd1;
        return $urandom;
    endfunction

    // Indexes: mostly inside the current length, some just past it, some anywhere.
    function automatic logic [IDX_W-1:0] pick_index(int unsigned len);
        int unsigned r;
        int unsigned hi;
        r = $urandom_range(0, 99);
        if (len > 0 && r < 65) return IDX_W'($urandom_range(0, len - 1));
        if (r < 85)
        begin
            if (len >= 63) return IDX_W'(63);
            hi = (len + 3 > 63) ? 63 : len + 3;
            return IDX_W'($urandom_range(len, hi));
        end
        return IDX_W'($urandom_range(0, 63));
    endfunction

    // Reply side: check every accepted item, stall in random bursts unless calm.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_reply(rsp_ch.status, rsp_ch.length, rsp_ch.element_at_index);
            if (calm)
            begin
                stall_left = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase_len;
        int unsigned mode;
        int unsigned ins_pct;
        int unsigned k;
        logic        cmd;

        sb = new();
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = iair_pkg::CMD_INSERT;
        req_ch.index   = '0;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, light idling on both sides.
        gap_pct   = 20;
        stall_pct = 20;
        send_edit(iair_pkg::CMD_REMOVE, 6'd0,  32'sd0);          // remove on empty array
        send_edit(iair_pkg::CMD_REMOVE, 6'd63, -32'sd1);         // beyond length, value ignored
        send_edit(iair_pkg::CMD_INSERT, 6'd0,  32'sd0);          // append a zero
        send_edit(iair_pkg::CMD_INSERT, 6'd0,  32'sh7FFF_FFFF);  // overwrite zero entry
        send_edit(iair_pkg::CMD_INSERT, 6'd0,  32'sh8000_0000);  // nonzero entry: shift up
        send_edit(iair_pkg::CMD_INSERT, 6'd5,  -32'sd1);         // grow with zero fill
        send_edit(iair_pkg::CMD_INSERT, 6'd3,  32'sh5555_5555);  // fill-in zero overwritten
        send_edit(iair_pkg::CMD_INSERT, 6'd3,  32'shAAAA_AAAA);  // shift up mid-array
        send_edit(iair_pkg::CMD_REMOVE, 6'd7,  32'sd0);          // index equal to length
        send_edit(iair_pkg::CMD_REMOVE, 6'd6,  32'sh1234_5678);  // remove last entry
        send_edit(iair_pkg::CMD_REMOVE, 6'd0,  32'sd0);          // remove first entry
        send_edit(iair_pkg::CMD_INSERT, 6'd63, 32'sd1);          // grow to full capacity
        send_edit(iair_pkg::CMD_INSERT, 6'd63, 32'sd2);          // shift when full: refused
        send_edit(iair_pkg::CMD_INSERT, 6'd10, 32'sd3);          // zero slot when full: allowed
        send_edit(iair_pkg::CMD_INSERT, 6'd10, 32'sd4);          // now occupied: refused
        send_edit(iair_pkg::CMD_REMOVE, 6'd63, 32'sd0);          // shrink from full
        send_edit(iair_pkg::CMD_INSERT, 6'd62, 32'sd5);          // zero slot overwrite
        send_edit(iair_pkg::CMD_INSERT, 6'd62, 32'sd6);          // shift back up to full
        send_edit(iair_pkg::CMD_INSERT, 6'd0,  32'sd7);          // refused again at the front
        send_edit(iair_pkg::CMD_REMOVE, 6'd0,  32'sd0);
        send_edit(iair_pkg::CMD_INSERT, 6'd63, 32'sd8);          // append at last slot again

        // Random part in phases: growing, shrinking or balanced mixes of edits,
        // with a fresh idling profile per phase; the tail runs with no idling.
        sent = 0;
        while (sent < 1900)
        begin
            mode      = $urandom_range(0, 2);
            phase_len = $urandom_range(40, 150);
            ins_pct   = (mode == 0) ? 80 : (mode == 1) ? 25 : 50;
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 35;
            endcase
            for (k = 0; k < phase_len && sent < 1900; k++)
            begin
                if (sent >= 1700)
                    calm = 1'b1;
                cmd = ($urandom_range(0, 99) < ins_pct) ? iair_pkg::CMD_INSERT
                                                        : iair_pkg::CMD_REMOVE;
                send_edit(cmd, pick_index(sb.shadow_len), pick_word());
                sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray reply item.
        while (sb.due_replies.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
